// File: rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared definitions for the ADC frame check and average unit
// Field widths, register indexes, status codes and the structs passed
// between the decoder, the shared subtractor and the sequencer.
// ----------------------------------------------------------------------------
package afc_pkg;

   // Fixed geometry of the response frame and the sample.
   localparam int FRAME_BYTES  = 4;
   localparam int FRAME_WIDTH  = 8 * FRAME_BYTES;
   localparam int SAMPLE_WIDTH = 12;
   localparam int COUNT_WIDTH  = 8;
   localparam int SUM_WIDTH    = 20;
   localparam int RATE_WIDTH   = SAMPLE_WIDTH + 1;
   localparam int MAX_AVERAGE  = 255;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AVERAGE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GYRO_OFFSET   = 2'd1;
   localparam logic [COUNT_WIDTH-1:0]     AVERAGE_COUNT_RESET = 8'd10;

   // Width of the shared subtractor operands.
   localparam int SUB_WIDTH = RATE_WIDTH;

   typedef enum logic [1:0] {
      STATUS_COHERENT   = 2'd0,
      STATUS_SLIP       = 2'd1,
      STATUS_INCOHERENT = 2'd2,
      STATUS_FAILED     = 2'd3
   } status_type;

   // Result of comparing the two sample copies in one frame.
   typedef struct packed {
      logic                    match;
      logic [SAMPLE_WIDTH-1:0] sample;
   } decode_type;

   // Result of the shared subtractor.
   typedef struct packed {
      logic                 borrow;
      logic [SUB_WIDTH-1:0] diff;
   } sub_result_type;

endpackage

// File: rtl/afc_decode.sv
// ----------------------------------------------------------------------------
// afc_decode: sample copy extraction and compare
// Pulls the MSB-first and LSB-first copies of the sample out of one frame
// and reports whether they agree.
// ----------------------------------------------------------------------------
module afc_decode (
   input  logic [afc_pkg::FRAME_WIDTH-1:0] frame,
   output afc_pkg::decode_type             decode
);
   import afc_pkg::*;

   logic [SAMPLE_WIDTH-1:0] msb_copy;
   logic [SAMPLE_WIDTH-1:0] lsb_copy;

   // The MSB-first copy is contiguous, B11 at bit 24 down to B0 at bit 13.
   assign msb_copy = frame[24:13];

   // The LSB-first copy starts at the shared B0 and runs down the stream.
   always_comb begin
      for (int k = 0; k < SAMPLE_WIDTH; k++) begin
         lsb_copy[k] = frame[13-k];
      end
   end

   assign decode.match  = (msb_copy == lsb_copy);
   assign decode.sample = msb_copy;

endmodule

// File: rtl/afc_sub.sv
// ----------------------------------------------------------------------------
// afc_sub: shared subtractor
// One subtract with borrow out, used for each restoring division step and
// for the final offset subtraction.
// ----------------------------------------------------------------------------
module afc_sub (
   input  logic [afc_pkg::SUB_WIDTH-1:0] op_a,
   input  logic [afc_pkg::SUB_WIDTH-1:0] op_b,
   output afc_pkg::sub_result_type       result
);
   import afc_pkg::*;

   logic [SUB_WIDTH:0] full_diff;

   // The extra top bit of the difference is the borrow.
   assign full_diff     = {1'b0, op_a} - {1'b0, op_b};
   assign result.borrow = full_diff[SUB_WIDTH];
   assign result.diff   = full_diff[SUB_WIDTH-1:0];

endmodule

// File: rtl/adc_frame_check_average_unit.sv
// ----------------------------------------------------------------------------
// adc_frame_check_average_unit: ADC response frame checker and averager
// Checks each frame's two sample copies, keeps a running window of good
// samples and reports the window mean and the mean less the gyro offset.
// ----------------------------------------------------------------------------
// A frame beat is taken only while the sequencer is idle. Its result beat is
// presented on rsp_valid from the output register after the check, accumulate
// and finish states (the check repeats once when the frame needs the one-bit
// slip retry); a frame that closes an averaging window also passes the divide
// and rate states before finish: the mean comes from a restoring divider that
// produces one quotient bit per cycle on the shared subtractor, and the offset
// subtraction takes one more pass through it. A new frame may be taken while
// the previous result beat still waits on rsp_ready; the sequencer then holds
// its finished result until the output register frees.
// The configuration port is always ready; writes belong to idle periods.
// ----------------------------------------------------------------------------
module adc_frame_check_average_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Frame input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [afc_pkg::FRAME_WIDTH-1:0]     req_frame,
   input  logic                                req_transfer_ok,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_frame_status,
   output logic [afc_pkg::SAMPLE_WIDTH-1:0]    rsp_sample,
   output logic                                rsp_average_done,
   output logic [afc_pkg::SAMPLE_WIDTH-1:0]    rsp_average,
   output logic signed [afc_pkg::RATE_WIDTH-1:0] rsp_rate,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [afc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [afc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import afc_pkg::*;

   localparam int STEP_WIDTH = $clog2(SAMPLE_WIDTH);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(SAMPLE_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ACCUM,
      ST_DIVIDE,
      ST_RATE,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [COUNT_WIDTH-1:0]  average_count_ff;
   logic [SAMPLE_WIDTH-1:0] gyro_offset_ff;

   // Sequencer state and work registers.
   state_type               state_ff, state_in;
   logic [FRAME_WIDTH-1:0]  frame_ff, frame_in;
   logic                    ok_ff, ok_in;
   logic                    slip_ff, slip_in;
   status_type              status_ff, status_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                    done_ff, done_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [COUNT_WIDTH-1:0]  rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0] work_ff, work_in;
   logic [COUNT_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [RATE_WIDTH-1:0]   rate_ff, rate_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic [SAMPLE_WIDTH-1:0] rsp_average_ff, rsp_average_in;
   logic [RATE_WIDTH-1:0]   rsp_rate_ff, rsp_rate_in;

   // Datapath helpers.
   decode_type              decode;
   sub_result_type          sub_result;
   logic [SUB_WIDTH-1:0]    sub_a;
   logic [SUB_WIDTH-1:0]    sub_b;
   logic [COUNT_WIDTH:0]    partial_rem;
   logic [COUNT_WIDTH-1:0]  limit;
   logic [COUNT_WIDTH-1:0]  count_next;
   logic [SUM_WIDTH-1:0]    sum_next;
   logic                    out_free;

   afc_decode u_decode (
      .frame  (frame_ff),
      .decode (decode)
   );

   afc_sub u_sub (
      .op_a   (sub_a),
      .op_b   (sub_b),
      .result (sub_result)
   );

   // Configuration writes; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         average_count_ff <= AVERAGE_COUNT_RESET;
         gyro_offset_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_AVERAGE_COUNT: average_count_ff <= csr_wdata[COUNT_WIDTH-1:0];
            REG_GYRO_OFFSET:   gyro_offset_ff   <= csr_wdata[SAMPLE_WIDTH-1:0];
            default:           ;
         endcase
      end
   end

   // Effective window length: zero counts as one, clamp at the maximum.
   always_comb begin
      limit = average_count_ff;
      if (limit == '0) begin
         limit = COUNT_WIDTH'(1);
      end
      if (limit > COUNT_WIDTH'(MAX_AVERAGE)) begin
         limit = COUNT_WIDTH'(MAX_AVERAGE);
      end
   end

   assign count_next = count_ff + COUNT_WIDTH'(1);
   assign sum_next   = sum_ff + SUM_WIDTH'(sample_ff);

   // Partial remainder of the current division step.
   assign partial_rem = {rem_ff, work_ff[SAMPLE_WIDTH-1]};

   // Shared subtractor operands: division step or offset subtraction.
   always_comb begin
      if (state_ff == ST_RATE) begin
         sub_a = {1'b0, work_ff};
         sub_b = {1'b0, gyro_offset_ff};
      end else begin
         sub_a = SUB_WIDTH'(partial_rem);
         sub_b = SUB_WIDTH'(divisor_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      frame_in       = frame_ff;
      ok_in          = ok_ff;
      slip_in        = slip_ff;
      status_in      = status_ff;
      sample_in      = sample_ff;
      done_in        = done_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      work_in        = work_ff;
      divisor_in     = divisor_ff;
      step_in        = step_ff;
      rate_in        = rate_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_average_in = rsp_average_ff;
      rsp_rate_in    = rsp_rate_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frame_in = req_frame;
               ok_in    = req_transfer_ok;
               slip_in  = 1'b0;
               done_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end

         // Fail a bad transfer, else compare the copies; on a mismatch slip the frame by one bit once.
         ST_CHECK: begin
            if (!ok_ff) begin
               status_in = STATUS_FAILED;
               sample_in = '0;
               state_in  = ST_ACCUM;
            end else if (decode.match) begin
               status_in = slip_ff ? STATUS_SLIP : STATUS_COHERENT;
               sample_in = decode.sample;
               state_in  = ST_ACCUM;
            end else if (!slip_ff) begin
               frame_in = {1'b0, frame_ff[FRAME_WIDTH-1:1]};
               slip_in  = 1'b1;
            end else begin
               status_in = STATUS_INCOHERENT;
               sample_in = '0;
               state_in  = ST_ACCUM;
            end
         end

         // Add a good sample to the window and start the mean when it closes.
         ST_ACCUM: begin
            state_in = ST_FINISH;
            if (status_ff == STATUS_COHERENT || status_ff == STATUS_SLIP) begin
               sum_in   = sum_next;
               count_in = count_next;
               if (count_next >= limit) begin
                  // The mean fits in 12 bits, so the top of the sum is
                  // already a valid starting remainder.
                  done_in    = 1'b1;
                  rem_in     = sum_next[SUM_WIDTH-1:SAMPLE_WIDTH];
                  work_in    = sum_next[SAMPLE_WIDTH-1:0];
                  divisor_in = count_next;
                  step_in    = '0;
                  sum_in     = '0;
                  count_in   = '0;
                  state_in   = ST_DIVIDE;
               end
            end
         end

         // One restoring division step per cycle; quotient shifts into work.
         ST_DIVIDE: begin
            if (sub_result.borrow) begin
               rem_in = partial_rem[COUNT_WIDTH-1:0];
            end else begin
               rem_in = sub_result.diff[COUNT_WIDTH-1:0];
            end
            work_in = {work_ff[SAMPLE_WIDTH-2:0], !sub_result.borrow};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_RATE;
            end
         end

         // Mean minus the gyro offset, wrapped to 13 bits.
         ST_RATE: begin
            rate_in  = sub_result.diff;
            state_in = ST_FINISH;
         end

         // Hand the result to the output register once it is free.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_sample_in  = sample_ff;
               rsp_done_in    = done_ff;
               rsp_average_in = done_ff ? work_ff : '0;
               rsp_rate_in    = done_ff ? rate_ff : '0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, window and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff       <= frame_in;
      ok_ff          <= ok_in;
      slip_ff        <= slip_in;
      status_ff      <= status_in;
      sample_ff      <= sample_in;
      done_ff        <= done_in;
      rem_ff         <= rem_in;
      work_ff        <= work_in;
      divisor_ff     <= divisor_in;
      step_ff        <= step_in;
      rate_ff        <= rate_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_average_ff <= rsp_average_in;
      rsp_rate_ff    <= rsp_rate_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_average_done = rsp_done_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_rate         = rsp_rate_ff;

`ifndef SYNTH
   // The remainder must stay below the divisor through the division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < divisor_ff))
      else $error("division remainder not below divisor");

   // A taken frame beat keeps the input closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input reopened while a frame is in work");

   // Only a good frame can close a window.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_average_done) |->
         (rsp_frame_status == STATUS_COHERENT || rsp_frame_status == STATUS_SLIP))
      else $error("window closed by a bad frame");

   // Mean and rate read zero unless a window closed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_done) |-> (rsp_average == '0 && rsp_rate == '0))
      else $error("mean reported without a closed window");

   // A bad frame carries no sample.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_status == STATUS_INCOHERENT ||
                     rsp_frame_status == STATUS_FAILED)) |-> (rsp_sample == '0))
      else $error("sample reported for a bad frame");
`endif

endmodule
